// ===== hdl/msmd_pkg.sv =====
package msmd_pkg;

   localparam int RawWidth   = 12;
   localparam int ThrWidth   = 12;
   localparam int ScaleWidth = 16;
   localparam int MoveWidth  = 5;
   localparam int FracBits   = 8;
   localparam int ProdWidth  = RawWidth + ScaleWidth;

   localparam logic [3:0] MoveLimit = 4'd10;

   localparam logic [1:0] RegThreshold  = 2'd0;
   localparam logic [1:0] RegHysteresis = 2'd1;
   localparam logic [1:0] RegScale      = 2'd2;
   localparam logic [1:0] RegSleep      = 2'd3;

   localparam logic [ThrWidth-1:0]   ThresholdReset  = 12'd15;
   localparam logic [ThrWidth-1:0]   HysteresisReset = 12'd10;
   localparam logic [ScaleWidth-1:0] ScaleReset      = 16'd256;

   typedef struct packed {
      logic [ThrWidth-1:0]   threshold;
      logic [ThrWidth-1:0]   hysteresis;
      logic [ScaleWidth-1:0] scale_q8;
   } msmd_axis_cfg_type;

endpackage

// ===== hdl/msmd_axis.sv =====
module msmd_axis import msmd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic [RawWidth-1:0]   raw,
   input  msmd_axis_cfg_type     cfg,
   output logic [MoveWidth-1:0]  move
);

   logic                         active_ff;
   logic                         active_in;
   logic                         neg;
   logic [RawWidth-1:0]          mag;
   logic signed [RawWidth:0]     low_mark;
   logic [ProdWidth-1:0]         prod;
   logic [ProdWidth-FracBits-1:0] amt;
   logic [3:0]                   lim;

   always_comb begin
      neg      = raw[RawWidth-1];
      mag      = neg ? RawWidth'(~raw + RawWidth'(1)) : raw;
      low_mark = $signed({1'b0, cfg.threshold}) - $signed({1'b0, cfg.hysteresis});

      active_in = active_ff;
      if (!active_ff && (mag > cfg.threshold)) begin
         active_in = 1'b1;
      end else if (active_ff && ($signed({1'b0, mag}) < low_mark)) begin
         active_in = 1'b0;
      end

      prod = {{ScaleWidth{1'b0}}, mag} * {{RawWidth{1'b0}}, cfg.scale_q8};
      amt  = prod[ProdWidth-1:FracBits];
      lim  = (amt > (ProdWidth-FracBits)'(MoveLimit)) ? MoveLimit : amt[3:0];

      if (!active_in) begin
         move = '0;
      end else if (neg) begin
         move = MoveWidth'(~{1'b0, lim} + MoveWidth'(1));
      end else begin
         move = {1'b0, lim};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (update) begin
         active_ff <= active_in;
      end
   end

endmodule

// ===== hdl/magnetic_stick_to_mouse_delta_unit.sv =====
// An accepted input beat waits in the input register and its result beat, if
// any, in the result register; each holds one item. One input beat is taken
// per cycle unless a result stalls; an empty input register takes one anyway.
// Reset (synchronous, active high) clears both activity flags, empties the
// pipeline and restores the register defaults.
module magnetic_stick_to_mouse_delta_unit import msmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // x_high[7:0], y_high[15:8], xy_low[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // move_x[4:0], move_y[9:5], zero[15:10]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [ThrWidth-1:0]    threshold_ff;
   logic [ThrWidth-1:0]    hysteresis_ff;
   logic [ScaleWidth-1:0]  scale_ff;
   logic                   sleep_ff;
   logic                   cfg_write;
   logic [1:0]             cfg_index;
   msmd_axis_cfg_type      axis_cfg;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [23:0]            s1_data_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [2*MoveWidth-1:0] rsp_data_ff;

   logic                   out_free;
   logic                   advance;
   logic                   update;
   logic                   emit;
   logic [RawWidth-1:0]    x_raw;
   logic [RawWidth-1:0]    y_raw;
   logic [MoveWidth-1:0]   move_x;
   logic [MoveWidth-1:0]   move_y;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= ThresholdReset;
         hysteresis_ff <= HysteresisReset;
         scale_ff      <= ScaleReset;
         sleep_ff      <= 1'b0;
      end else if (cfg_write) begin
         case (cfg_index)
            RegThreshold:  threshold_ff  <= csr_pwdata[ThrWidth-1:0];
            RegHysteresis: hysteresis_ff <= csr_pwdata[ThrWidth-1:0];
            RegScale:      scale_ff      <= csr_pwdata[ScaleWidth-1:0];
            RegSleep:      sleep_ff      <= csr_pwdata[0];
            default:       sleep_ff      <= sleep_ff;
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         RegThreshold:  csr_prdata = {20'd0, threshold_ff};
         RegHysteresis: csr_prdata = {20'd0, hysteresis_ff};
         RegScale:      csr_prdata = {16'd0, scale_ff};
         RegSleep:      csr_prdata = {31'd0, sleep_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign axis_cfg.threshold  = threshold_ff;
   assign axis_cfg.hysteresis = hysteresis_ff;
   assign axis_cfg.scale_q8   = scale_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign update     = advance && !sleep_ff;
   assign req_tready = !s1_valid_ff || out_free;

   assign x_raw = {s1_data_ff[7:0], s1_data_ff[23:20]};
   assign y_raw = {s1_data_ff[15:8], s1_data_ff[19:16]};

   msmd_axis u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .update (update),
      .raw    (x_raw),
      .cfg    (axis_cfg),
      .move   (move_x)
   );

   msmd_axis u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .update (update),
      .raw    (y_raw),
      .cfg    (axis_cfg),
      .move   (move_y)
   );

   assign emit = update && ((move_x != '0) || (move_y != '0));

   always_comb begin
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
      end
      if (emit) begin
         rsp_data_ff <= {move_y, move_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

endmodule

// ===== hdl/msmd_checker.sv =====
module msmd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result beat keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // A result beat never carries two zero deltas.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] != 5'd0) || (rsp_tdata[9:5] != 5'd0))
      else $error("result beat with no movement");

   // Both deltas stay within plus or minus ten and the padding is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[4:0]) <= 5'sd10)
         && ($signed(rsp_tdata[4:0]) >= -5'sd10)
         && ($signed(rsp_tdata[9:5]) <= 5'sd10)
         && ($signed(rsp_tdata[9:5]) >= -5'sd10)
         && (rsp_tdata[15:10] == 6'd0))
      else $error("delta out of range");

   // The result channel is empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind magnetic_stick_to_mouse_delta_unit msmd_checker u_msmd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
